[src/assert_macros.svh]
// assertion macros shared by the stack engine rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[src/ise_pkg.sv]
// shared types and codes for the indexed stack engine
// no dependencies; imported by every module of the block
`default_nettype none

package ise_pkg;

    localparam int DATA_W             = 32;
    localparam int POS_W              = 4;
    localparam int CNT_FIELD_W        = 4;
    localparam int DEFAULT_DEPTH      = 8;
    localparam int DEFAULT_WORD_WIDTH = 32;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_PEEP   = 2'd2;
    localparam logic [1:0] CMD_CHANGE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADPOS    = 2'd3;

    // store access the back end performs for one command
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [1:0]               status;
        logic [CNT_FIELD_W-1:0]   count;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]             op;
        logic [1:0]             status;
        logic [CNT_FIELD_W-1:0] count;
    } t_cmd_ctl;

endpackage

`default_nettype wire

[src/indexed_stack_engine_unit.sv]
// indexed stack engine: one command in, one result out, one command per cycle sustained
// while the output is not stalled. a command enters the queue on its input transfer and
// leaves it when the result register is free; its result is held there until taken.
// the back end issues one store access per cycle while the result register is free.
// reset (synchronous, active low) empties the stack, the queue and the result register;
// the word store itself is not cleared and only entries written by push are ever read.
`default_nettype none
`include "assert_macros.svh"

module indexed_stack_engine_unit #(
    parameter int DEPTH      = ise_pkg::DEFAULT_DEPTH,
    parameter int WORD_WIDTH = ise_pkg::DEFAULT_WORD_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ise_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ise_pkg::t_out_item o_out_item
);
    import ise_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int Q_W   = $bits(t_cmd_ctl) + IDX_W + DATA_W;
    localparam logic [CNT_FIELD_W-1:0] FULL_FIELD = CNT_FIELD_W'(DEPTH % 16);

    logic                     q_push;
    logic                     q_pop;
    logic                     q_full;
    logic                     q_empty;
    logic [Q_W-1:0]           q_din;
    logic [Q_W-1:0]           q_dout;
    t_cmd_ctl                 f_ctl;
    logic [IDX_W-1:0]         f_idx;
    logic signed [DATA_W-1:0] f_value;
    t_cmd_ctl                 b_ctl;
    logic [IDX_W-1:0]         b_idx;
    logic signed [DATA_W-1:0] b_value;
    logic                     ovf_shown;
    logic                     udf_shown;
    logic                     udf_fields_ok;

    ise_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_ctl    (f_ctl),
        .o_q_idx    (f_idx),
        .o_q_value  (f_value)
    );

    assign q_din = {f_ctl, f_idx, f_value};

    ise_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_din   (q_din),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_dout  (q_dout),
        .o_empty (q_empty)
    );

    assign {b_ctl, b_idx, b_value} = q_dout;

    ise_back #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_q_ctl     (b_ctl),
        .i_q_idx     (b_idx),
        .i_q_value   (b_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    assign ovf_shown     = o_out_valid && (o_out_item.status == ST_OVERFLOW);
    assign udf_shown     = o_out_valid && (o_out_item.status == ST_UNDERFLOW);
    assign udf_fields_ok = (o_out_item.count == '0) && (o_out_item.read_data == '1);

    // queue never written when full nor drained when empty
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, q_push && q_full)
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, q_pop && q_empty)
    // overflow only reported with a full stack
    `ASSERT_PROP(a_ovf_count, i_clk, i_rst_n, ovf_shown |-> (o_out_item.count == FULL_FIELD))
    // underflow leaves an empty stack and reads back all ones
    `ASSERT_PROP(a_udf_result, i_clk, i_rst_n, udf_shown |-> udf_fields_ok)

endmodule

`default_nettype wire

[src/ise_front.sv]
// front end: accepts commands, owns the held count, classifies each command
// depends on ise_pkg
`default_nettype none

module ise_front #(
    parameter int DEPTH = ise_pkg::DEFAULT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ise_pkg::t_in_item             i_in_item,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output ise_pkg::t_cmd_ctl             o_q_ctl,
    output logic [$clog2(DEPTH)-1:0]      o_q_idx,
    output logic signed [ise_pkg::DATA_W-1:0] o_q_value
);
    import ise_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] depth_diff;
    logic [CMP_W-1:0] n_count_ext;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_q_push   = accept;
    assign o_q_value  = i_in_item.value;

    assign pos_ext     = CMP_W'(i_in_item.position);
    assign cnt_ext     = CMP_W'(r_count);
    assign depth_diff  = cnt_ext - pos_ext;
    assign n_count_ext = CMP_W'(n_count);

    always_comb begin
        n_count         = r_count;
        o_q_ctl.op      = OP_NONE;
        o_q_ctl.status  = ST_OK;
        o_q_idx         = '0;
        case (i_in_item.cmd)
            CMD_PUSH: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    o_q_ctl.status = ST_OVERFLOW;
                end else begin
                    o_q_ctl.op = OP_WRITE;
                    o_q_idx    = r_count[IDX_W-1:0];
                    n_count    = r_count + 1'b1;
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    o_q_ctl.status = ST_UNDERFLOW;
                end else begin
                    n_count    = r_count - 1'b1;
                    o_q_ctl.op = OP_READ;
                    o_q_idx    = n_count[IDX_W-1:0];
                end
            end
            CMD_PEEP, CMD_CHANGE: begin
                if (pos_ext == '0 || pos_ext > cnt_ext) begin
                    o_q_ctl.status = ST_BADPOS;
                end else begin
                    o_q_ctl.op = (i_in_item.cmd == CMD_PEEP) ? OP_READ : OP_WRITE;
                    o_q_idx    = depth_diff[IDX_W-1:0];
                end
            end
            default: begin
                o_q_ctl.status = ST_OK;
            end
        endcase
        o_q_ctl.count = n_count_ext[CNT_FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

[src/ise_queue.sv]
// two-entry queue decoupling the front end from the back end
// depends on ise_pkg only by convention; payload width is a parameter
`default_nettype none

module ise_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_empty
);
    import ise_pkg::*;

    localparam int ENTRIES = 2;
    localparam int PTR_W   = $clog2(ENTRIES);
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    logic [WIDTH-1:0] r_slot [ENTRIES];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [OCC_W-1:0] r_occ;

    assign o_full  = (r_occ == OCC_W'(ENTRIES));
    assign o_empty = (r_occ == '0);
    assign o_dout  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_occ <= r_occ + 1'b1;
            end else if (i_pop && !i_push) begin
                r_occ <= r_occ - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[src/ise_back.sv]
// back end: word store, store access and the result register
// depends on ise_pkg
`default_nettype none

module ise_back #(
    parameter int DEPTH      = ise_pkg::DEFAULT_DEPTH,
    parameter int WORD_WIDTH = ise_pkg::DEFAULT_WORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    output logic                              o_q_pop,
    input  ise_pkg::t_cmd_ctl                 i_q_ctl,
    input  logic [$clog2(DEPTH)-1:0]          i_q_idx,
    input  logic signed [ise_pkg::DATA_W-1:0] i_q_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ise_pkg::t_out_item                o_out_item
);
    import ise_pkg::*;

    logic signed [WORD_WIDTH-1:0] r_store [DEPTH];
    logic signed [WORD_WIDTH-1:0] r_rd_q;
    logic signed [WORD_WIDTH-1:0] wr_word;
    t_cmd_ctl                     r_ctl;
    logic                         r_out_valid;
    logic                         issue;

    assign issue   = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_q_pop = issue;
    assign wr_word = WORD_WIDTH'(i_q_value);

    always_ff @(posedge i_clk) begin
        if (issue && i_q_ctl.op == OP_WRITE) begin
            r_store[i_q_idx] <= wr_word;
        end
        if (issue && i_q_ctl.op == OP_READ) begin
            r_rd_q <= r_store[i_q_idx];
        end
        if (issue) begin
            r_ctl <= i_q_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (issue) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        if (r_ctl.op == OP_READ) begin
            o_out_item.read_data = DATA_W'(r_rd_q);
        end else if (r_ctl.status == ST_UNDERFLOW) begin
            o_out_item.read_data = '1;
        end else begin
            o_out_item.read_data = '0;
        end
        o_out_item.status = r_ctl.status;
        o_out_item.count  = r_ctl.count;
    end

endmodule

`default_nettype wire

[verif/indexed_stack_engine_unit_tb.sv]
// testbench for indexed_stack_engine_unit: directed and random stack commands, checked
// against a shadow stack kept here, with random idling on both sides and a long output hold
// depends on ise_pkg and the indexed_stack_engine_unit rtl
`timescale 1ns / 100ps

module indexed_stack_engine_unit_tb;
    import ise_pkg::*;

    localparam int STACK_DEPTH  = DEFAULT_DEPTH;
    localparam int HOLD_CYCLES  = 60;
    localparam int LIMIT_CYCLES = 100000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // shadow copy of the stack contents
    logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
    int                       shadow_level = 0;
    t_out_item                pending_results [$];

    int issued_level  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int cycle_count   = 0;

    indexed_stack_engine_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_out_item stack_predict(input t_in_item item);
        t_out_item res;
        int        idx;
        res.read_data = '0;
        res.status    = ST_OK;
        case (item.cmd)
            CMD_PUSH: begin
                if (shadow_level >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_words[shadow_level] = item.value;
                    shadow_level++;
                end
            end
            CMD_POP: begin
                if (shadow_level == 0) begin
                    res.status    = ST_UNDERFLOW;
                    res.read_data = -1;
                end else begin
                    shadow_level--;
                    res.read_data = shadow_words[shadow_level];
                end
            end
            default: begin
                if (item.position == 0 || int'(item.position) > shadow_level) begin
                    res.status = ST_BADPOS;
                end else begin
                    idx = shadow_level - int'(item.position);
                    if (item.cmd == CMD_PEEP)
                        res.read_data = shadow_words[idx];
                    else
                        shadow_words[idx] = item.value;
                end
            end
        endcase
        res.count = CNT_FIELD_W'(shadow_level);
        return res;
    endfunction

    // input transfers feed the shadow stack, output transfers are checked against it
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n) begin
            if (in_valid && !o_in_stall)
                pending_results.push_back(stack_predict(in_item));
            if (o_out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_item);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, o_out_item.read_data);
                        err_count++;
                    end
                    if (o_out_item.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_out_item.status);
                        err_count++;
                    end
                    if (o_out_item.count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, o_out_item.count);
                        err_count++;
                    end
                end
            end
        end
    end

    // output side: random stalls, or a long hold when requested
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [DATA_W-1:0] value,
                            input logic [POS_W-1:0] position);
        t_in_item item;
        item.cmd      = cmd;
        item.value    = value;
        item.position = position;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        case (cmd)
            CMD_PUSH: if (issued_level < STACK_DEPTH) issued_level++;
            CMD_POP:  if (issued_level > 0) issued_level--;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // empty stack: underflow and bad positions
        send_cmd(CMD_POP, 32'h1234_5678, 4'd0);
        send_cmd(CMD_PEEP, 32'h0, 4'd0);
        send_cmd(CMD_CHANGE, 32'hdead_beef, 4'd1);
        send_cmd(CMD_PUSH, 32'h8000_0000, 4'd0);
        send_cmd(CMD_PUSH, 32'h7fff_ffff, 4'd15);
        send_cmd(CMD_PUSH, 32'hffff_ffff, 4'd0);
        send_cmd(CMD_PUSH, 32'h0, 4'd0);
        send_cmd(CMD_PEEP, 32'h0, 4'd1);
        send_cmd(CMD_PEEP, 32'hffff_ffff, 4'd4);
        send_cmd(CMD_PEEP, 32'h0, 4'd5);
        send_cmd(CMD_CHANGE, 32'h5a5a_a5a5, 4'd3);
        send_cmd(CMD_PEEP, 32'h0, 4'd3);
        for (int i = 0; i < 4; i++)
            send_cmd(CMD_PUSH, 32'h1357_9bdf ^ (32'h1111_1111 * i), 4'd0);
        // full stack: overflow, deepest position, out of range positions
        send_cmd(CMD_PUSH, 32'h0bad_0bad, 4'd0);
        send_cmd(CMD_CHANGE, 32'hc0de_0001, 4'd8);
        send_cmd(CMD_PEEP, 32'h0, 4'd8);
        send_cmd(CMD_PEEP, 32'h0, 4'd15);
        send_cmd(CMD_CHANGE, 32'h7777_7777, 4'd9);
        for (int i = 0; i < STACK_DEPTH + 1; i++)
            send_cmd(CMD_POP, 32'h0, 4'd0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        logic [1:0]        cmd;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  position;
        int                roll;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        repeat (n_items) begin
            roll = $urandom_range(99);
            case ($urandom_range(15))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                2:       value = '0;
                3:       value = '1;
                default: value = $urandom;
            endcase
            if (roll < 10) begin
                // noise: any command at any position
                cmd      = 2'($urandom_range(3));
                position = 4'($urandom_range(15));
            end else begin
                if (roll < 45)
                    cmd = CMD_PUSH;
                else if (roll < 68)
                    cmd = CMD_POP;
                else if (roll < 85)
                    cmd = CMD_PEEP;
                else
                    cmd = CMD_CHANGE;
                if (issued_level == 0)
                    cmd = CMD_PUSH;
                else if (issued_level == STACK_DEPTH && cmd == CMD_PUSH
                         && $urandom_range(3) != 0)
                    cmd = CMD_POP;
                position = (issued_level == 0) ? 4'd1
                                               : 4'($urandom_range(issued_level, 1));
            end
            send_cmd(cmd, value, position);
        end
        wait_drained();
    endtask

    // hold the output long enough that the block backs up into its input
    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 40; i++)
            send_cmd((i % 3 == 2) ? CMD_POP : CMD_PUSH, $urandom, 4'($urandom_range(15)));
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(300, 35, 62);
        test_random_traffic(300, 62, 35);
        test_random_traffic(300, 0, 0);
        test_output_hold();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
